>>> hdl/udv_pkg.sv
// Package for the ultrasonic distance vote block.
// Holds the job and configuration structs, status codes and conversion constants.
// No dependencies; every module of the block imports it.
package udv_pkg;

  localparam int unsigned CM_W      = 7;
  localparam int unsigned WIDTH_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Widths above this are timeouts (80 cm).
  localparam logic [WIDTH_W-1:0] TIMEOUT_US = 13'd4656;

  // cm = floor(w*5/291); the reciprocal 225/2^16 underestimates by at most one.
  localparam logic [14:0] CM_DIVISOR = 15'd291;
  localparam logic [8:0]  CM_RECIP   = 9'd225;
  localparam int unsigned CM_SHIFT   = 16;

  // floor(s/3) == (s*171) >> 9 for every s up to 255.
  localparam logic [8:0] THIRD_RECIP = 9'd171;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AGREE_TOL  = 2'd0,
    REG_NEAR_LIMIT = 2'd1,
    REG_SIDE_LIMIT = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_SLOW_DOWN  = 3'd0,
    ST_ALL_AGREE  = 3'd1,
    ST_ONE_ERROR  = 3'd2,
    ST_TWO_ERROR  = 3'd3,
    ST_ALL_ERROR  = 3'd4,
    ST_NO_REPORT  = 3'd5
  } status_t;

  typedef struct packed {
    logic [CM_W-1:0] agree_tol;
    logic [CM_W-1:0] near_limit;
    logic [CM_W-1:0] side_limit;
  } cfg_t;

  // One complete round of readings waiting for a vote.
  typedef struct packed {
    logic [CM_W-1:0] front0;
    logic [CM_W-1:0] front1;
    logic [CM_W-1:0] front2;
    logic [CM_W-1:0] rear;
  } job_t;

endpackage

>>> hdl/udv_front.sv
// Front end of the distance vote: converts echo widths to cm and collects a round.
// Depends on udv_pkg; pushes a job_t into udv_queue when the rear beat is accepted.
module udv_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [udv_pkg::WIDTH_W-1:0]   echo_width,
  input  logic                          q_full,
  output logic                          q_push,
  output udv_pkg::job_t                 q_job
);
  import udv_pkg::*;

  logic [1:0]      slot;
  logic [CM_W-1:0] front0;
  logic [CM_W-1:0] front1;
  logic [CM_W-1:0] front2;
  logic            accept;
  logic            rear_slot;
  logic [14:0]     scaled;
  logic [23:0]     product;
  logic [CM_W-1:0] quot_est;
  logic [14:0]     remainder;
  logic [CM_W-1:0] cm;

  assign rear_slot = (slot == 2'd3);
  // Only the rear beat needs queue space, so the other slots never stall.
  assign in_stall  = q_full && rear_slot;
  assign accept    = in_valid && !in_stall;

  // Constant division by multiplication with a one-step correction.
  always_comb begin
    scaled    = 15'(echo_width) * 15'd5;
    product   = 24'(scaled) * 24'(CM_RECIP);
    quot_est  = product[CM_SHIFT +: CM_W];
    remainder = scaled - 15'(quot_est) * CM_DIVISOR;
    if (echo_width > TIMEOUT_US) begin
      cm = '0;
    end else if (remainder >= CM_DIVISOR) begin
      cm = quot_est + 7'd1;
    end else begin
      cm = quot_est;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= '0;
      front0 <= '0;
      front1 <= '0;
      front2 <= '0;
    end else if (accept) begin
      slot <= slot + 2'd1;
      unique case (slot)
        2'd0:    front0 <= cm;
        2'd1:    front1 <= cm;
        2'd2:    front2 <= cm;
        default: ;
      endcase
    end
  end

  assign q_push       = accept && rear_slot;
  assign q_job.front0 = front0;
  assign q_job.front1 = front1;
  assign q_job.front2 = front2;
  assign q_job.rear   = cm;

endmodule

>>> hdl/udv_queue.sv
// Small FIFO of vote jobs between the front end and the voter.
// Depends on udv_pkg for job_t; depth comes from the top level.
module udv_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  udv_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output udv_pkg::job_t  head_job
);
  import udv_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/udv_back.sv
// Back end of the distance vote: votes over one round and holds the result beat.
// Depends on udv_pkg; pops jobs from udv_queue, reads cfg_t from the top level.
module udv_back (
  input  logic                       clk,
  input  logic                       rst,
  input  udv_pkg::cfg_t              cfg,
  input  logic                       head_valid,
  input  udv_pkg::job_t              head_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output udv_pkg::status_t           status,
  output logic [udv_pkg::CM_W-1:0]   distance
);
  import udv_pkg::*;

  logic            load;
  logic            agree01;
  logic            agree02;
  logic            agree12;
  logic            any_low;
  logic            slow;
  logic [1:0]      pairs;
  logic [7:0]      pair_sum;
  logic [7:0]      sum3;
  logic [16:0]     third;
  status_t         status_next;
  logic [CM_W-1:0] distance_next;

  function automatic logic agrees(logic [CM_W-1:0] a, logic [CM_W-1:0] b,
                                  logic [CM_W-1:0] tol);
    logic [CM_W-1:0] diff;
    diff = (a > b) ? a - b : b - a;
    return (a != '0) && (b != '0) && (diff <= tol);
  endfunction

  assign agree01 = agrees(head_job.front0, head_job.front1, cfg.agree_tol);
  assign agree02 = agrees(head_job.front0, head_job.front2, cfg.agree_tol);
  assign agree12 = agrees(head_job.front1, head_job.front2, cfg.agree_tol);
  assign pairs   = 2'(agree01) + 2'(agree02) + 2'(agree12);

  // A zero reading is below any limit, so the compare alone covers it
  // except when the limit itself is zero.
  assign any_low = (head_job.front0 == '0) || (head_job.front0 < cfg.side_limit)
                || (head_job.front1 == '0) || (head_job.front1 < cfg.side_limit)
                || (head_job.front2 == '0) || (head_job.front2 < cfg.side_limit);
  assign slow    = (head_job.rear != '0) && (head_job.rear < cfg.near_limit) && any_low;

  // Six pair members sum to twice the three readings, so the mean is sum/3.
  assign sum3  = 8'(head_job.front0) + 8'(head_job.front1) + 8'(head_job.front2);
  assign third = 17'(sum3) * 17'(THIRD_RECIP);

  always_comb begin
    priority if (agree01) begin
      pair_sum = 8'(head_job.front0) + 8'(head_job.front1);
    end else if (agree02) begin
      pair_sum = 8'(head_job.front0) + 8'(head_job.front2);
    end else begin
      pair_sum = 8'(head_job.front1) + 8'(head_job.front2);
    end
  end

  always_comb begin
    priority if (slow) begin
      status_next   = ST_SLOW_DOWN;
      distance_next = head_job.rear;
    end else if (pairs == 2'd3) begin
      status_next   = ST_ALL_AGREE;
      distance_next = third[9 +: CM_W];
    end else if (pairs == 2'd1) begin
      status_next   = ST_ONE_ERROR;
      distance_next = pair_sum[CM_W:1];
    end else if (pairs == 2'd2) begin
      status_next   = ST_NO_REPORT;
      distance_next = '0;
    end else if (head_job.front0 != '0) begin
      status_next   = ST_TWO_ERROR;
      distance_next = head_job.front0;
    end else if (head_job.front1 != '0) begin
      status_next   = ST_TWO_ERROR;
      distance_next = head_job.front1;
    end else if (head_job.front2 != '0) begin
      status_next   = ST_TWO_ERROR;
      distance_next = head_job.front2;
    end else begin
      status_next   = ST_ALL_ERROR;
      distance_next = '0;
    end
  end

  // The output register refills whenever it is empty or being taken.
  assign load = !out_valid || !out_stall;
  assign pop  = head_valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status   <= status_next;
      distance <= distance_next;
    end
  end

endmodule

>>> hdl/ultrasonic_distance_vote.sv
// Top level of the ultrasonic distance vote block.
// Depends on udv_pkg, udv_front, udv_queue and udv_back.
//
// Usage:
//   The input channel (in_valid, in_stall, echo_width) takes one echo width in
//   microseconds per beat, 0 meaning timeout. Beats go to sensor slots 0, 1, 2
//   and 3 in turn; slot 3 is the rear sensor. Each width is turned into cm and
//   stored. The beat for slot 3 closes a round and produces exactly one result
//   beat on the output channel (out_valid, out_stall, status, distance); the
//   other beats produce none.
//   The rear beat's round is registered in the queue, and its vote in the output
//   register. Throughput: one input beat per cycle, sustained, as long as the
//   output is taken; the conversion happens in the cycle the beat is taken and
//   the vote once the round has reached the queue head.
//   A stalled receiver holds the result beat steady. Rounds then collect in a
//   QUEUE_DEPTH entry queue; only when that queue is full is the rear beat
//   stalled, while beats for slots 0 to 2 are still taken.
//   Synchronous reset clears the slot counter, the stored readings, the queue
//   and the output valid, and loads the tolerance 5, near limit 20 and side
//   limit 23. The configuration port writes one register per cycle with
//   cfg_write; index 0 tolerance, 1 near limit, 2 side limit, 3 ignored.
module ultrasonic_distance_vote #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [udv_pkg::WIDTH_W-1:0]     echo_width,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [udv_pkg::CM_W-1:0]        distance,
  input  logic                            cfg_write,
  input  logic [udv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [udv_pkg::CM_W-1:0]        cfg_data
);
  import udv_pkg::*;

  cfg_t    cfg;
  logic    q_full;
  logic    q_push;
  job_t    q_push_job;
  logic    q_pop;
  logic    q_head_valid;
  job_t    q_head_job;
  status_t status_reg;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.agree_tol  <= 7'd5;
      cfg.near_limit <= 7'd20;
      cfg.side_limit <= 7'd23;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AGREE_TOL:  cfg.agree_tol  <= cfg_data;
        REG_NEAR_LIMIT: cfg.near_limit <= cfg_data;
        REG_SIDE_LIMIT: cfg.side_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  udv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .echo_width (echo_width),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_push_job)
  );

  udv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  udv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status_reg),
    .distance   (distance)
  );

  assign status = status_reg;

`ifndef SYNTHESIS
  // The front end must never push a round into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("round pushed into a full queue");

  // Slow down always reports the rear reading, which is then nonzero.
  a_slow_distance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SLOW_DOWN) |-> (distance != '0))
    else $error("slow down reported with zero distance");

  // No report and all error carry no distance.
  a_zero_distance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_NO_REPORT || status == ST_ALL_ERROR))
      |-> (distance == '0))
    else $error("distance given with no report or all error");

  // A reset leaves no result beat pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat valid right after reset");
`endif

endmodule

>>> bench/udv_vote_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ultrasonic distance vote block. It predicts each vote from the
// accepted echo beats and register writes, and compares it with the result beats.
// Depends on udv_pkg.
module udv_vote_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [udv_pkg::WIDTH_W-1:0]   echo_width,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [2:0]                    status,
  input  logic [udv_pkg::CM_W-1:0]      distance,
  input  logic                          cfg_write,
  input  logic [udv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [udv_pkg::CM_W-1:0]      cfg_data,
  input  logic                          run_done,
  output int unsigned                   votes_owed,
  output int unsigned                   mismatches
);
  import udv_pkg::*;

  typedef struct packed {
    status_t         st;
    logic [CM_W-1:0] dist_cm;
  } vote_t;

  logic [CM_W-1:0] tol;
  logic [CM_W-1:0] near_lim;
  logic [CM_W-1:0] side_lim;
  logic [CM_W-1:0] cm_by_slot [4];
  logic [1:0]      slot;
  vote_t           pending_votes [$];
  bit              leftovers_counted = 1'b0;

  initial begin
    votes_owed = 0;
    mismatches = 0;
  end

  // Echo time in microseconds to whole centimetres; anything past 80 cm is a timeout.
  function automatic logic [CM_W-1:0] width_cm(logic [WIDTH_W-1:0] w);
    if (w > TIMEOUT_US) return '0;
    return CM_W'((32'(w) * 10) / 582);
  endfunction

  function automatic bit agree(logic [CM_W-1:0] a, logic [CM_W-1:0] b);
    logic [CM_W-1:0] gap;
    gap = (a > b) ? a - b : b - a;
    return a != 0 && b != 0 && gap <= tol;
  endfunction

  function automatic bit below_side(logic [CM_W-1:0] r);
    return r == 0 || r < side_lim;
  endfunction

  function automatic vote_t vote_round(logic [CM_W-1:0] f0, logic [CM_W-1:0] f1,
                                       logic [CM_W-1:0] f2, logic [CM_W-1:0] rear);
    vote_t       v;
    int unsigned pairs;
    int unsigned total;
    pairs = 0;
    total = 0;
    if (agree(f0, f1)) begin
      pairs++;
      total += int'(f0) + int'(f1);
    end
    if (agree(f0, f2)) begin
      pairs++;
      total += int'(f0) + int'(f2);
    end
    if (agree(f1, f2)) begin
      pairs++;
      total += int'(f1) + int'(f2);
    end
    v.dist_cm = '0;
    if (rear != 0 && rear < near_lim && (below_side(f0) || below_side(f1) || below_side(f2)))
    begin
      v.st      = ST_SLOW_DOWN;
      v.dist_cm = rear;
    end else if (pairs == 3) begin
      v.st      = ST_ALL_AGREE;
      v.dist_cm = CM_W'(total / 6);
    end else if (pairs == 1) begin
      v.st      = ST_ONE_ERROR;
      v.dist_cm = CM_W'(total / 2);
    end else if (pairs == 2) begin
      v.st = ST_NO_REPORT;
    end else if (f0 != 0 || f1 != 0 || f2 != 0) begin
      v.st      = ST_TWO_ERROR;
      v.dist_cm = (f0 != 0) ? f0 : ((f1 != 0) ? f1 : f2);
    end else begin
      v.st = ST_ALL_ERROR;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    vote_t want;
    if (rst) begin
      tol      = 7'd5;
      near_lim = 7'd20;
      side_lim = 7'd23;
      foreach (cm_by_slot[i]) cm_by_slot[i] = '0;
      slot = '0;
      pending_votes.delete();
    end else begin
      // The result side is checked first; a vote never leaves in the cycle it is made.
      if (out_valid && !out_stall) begin
        if (pending_votes.size() == 0) begin
          $display("%0t: result beat status %0d distance %0d with no vote outstanding",
                   $time, status, distance);
          mismatches++;
        end else begin
          want = pending_votes.pop_front();
          if (status != want.st) begin
            $display("%0t: status expected %0d, got %0d", $time, want.st, status);
            mismatches++;
          end
          if (distance != want.dist_cm) begin
            $display("%0t: distance expected %0d, got %0d", $time, want.dist_cm, distance);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_AGREE_TOL:  tol = cfg_data;
          REG_NEAR_LIMIT: near_lim = cfg_data;
          REG_SIDE_LIMIT: side_lim = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        cm_by_slot[slot] = width_cm(echo_width);
        if (slot == 2'd3)
          pending_votes.push_back(vote_round(cm_by_slot[0], cm_by_slot[1],
                                             cm_by_slot[2], cm_by_slot[3]));
        slot = slot + 2'd1;
      end
    end
    if (run_done && !leftovers_counted) begin
      leftovers_counted = 1'b1;
      if (pending_votes.size() != 0) begin
        $display("%0t: %0d votes never arrived, next expected status %0d distance %0d",
                 $time, pending_votes.size(), pending_votes[0].st,
                 pending_votes[0].dist_cm);
        mismatches += pending_votes.size();
      end
    end
    votes_owed <= pending_votes.size();
  end

endmodule

>>> bench/ultrasonic_distance_vote_tb.sv
`timescale 1ns / 1ps
// Testbench top for ultrasonic_distance_vote: clock, reset, stimulus and the verdict.
// Depends on udv_pkg, the block itself and udv_vote_checker, which does all checking.
module ultrasonic_distance_vote_tb;
  import udv_pkg::*;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [WIDTH_W-1:0]   echo_width = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [2:0]           status;
  logic [CM_W-1:0]      distance;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CM_W-1:0]      cfg_data   = '0;
  logic                 run_done   = 1'b0;
  int unsigned          votes_owed;
  int unsigned          mismatches;

  // Idling knobs. The sender percentage is only used by the stimulus process. The stall
  // percentage and the hold ticket are read by the receiver process, so they are
  // written with nonblocking assignments.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_ticket   = 0;

  ultrasonic_distance_vote dut (.*);

  udv_vote_checker vote_check (.*);

  always #1 clk = ~clk;

  // Safety net: a hung handshake ends the run here.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver. Each cycle it stalls at random with the current percentage. When the
  // stimulus bumps the hold ticket it holds off for a long stretch instead. The
  // stretch is counted here so that the sender keeps offering beats meanwhile.
  initial begin
    int unsigned served;
    int unsigned hold_left;
    served    = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        served    = hold_ticket;
        hold_left = 150;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Smallest echo width in microseconds that converts to the given distance in cm.
  function automatic logic [WIDTH_W-1:0] cm_to_width(int cm);
    return WIDTH_W'((cm * 582 + 9) / 10);
  endfunction

  // A front reading scattered around a common base. Now and then it is a timeout or a
  // raw 13-bit value, which is often past the 80 cm limit.
  function automatic logic [WIDTH_W-1:0] front_width(int base, int spread);
    int cm;
    case ($urandom_range(15))
      0: return '0;
      1: return WIDTH_W'($urandom_range(8191));
      default: begin
        cm = base + int'($urandom_range(2 * spread)) - spread;
        if (cm < 0) cm = 0;
        if (cm > 80) cm = 80;
        // A few extra microseconds stay inside the same cm bucket, except at 80 cm,
        // where they tip the width just past the timeout.
        return cm_to_width(cm) + WIDTH_W'($urandom_range(5));
      end
    endcase
  endfunction

  // One echo beat. Sender gaps come first. Then valid is raised and held, with the
  // payload steady, until the beat is taken at an edge where stall is low.
  task automatic send_beat(input logic [WIDTH_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    echo_width <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // One full round: three front sensors, then the rear sensor, which triggers the vote.
  task automatic send_round(input logic [WIDTH_W-1:0] w0, input logic [WIDTH_W-1:0] w1,
                            input logic [WIDTH_W-1:0] w2, input logic [WIDTH_W-1:0] w3);
    send_beat(w0);
    send_beat(w1);
    send_beat(w2);
    send_beat(w3);
  endtask

  task automatic send_random_round();
    int                 base;
    int                 spread;
    logic [WIDTH_W-1:0] rear;
    base   = $urandom_range(80, 1);
    spread = $urandom_range(12);
    case ($urandom_range(3))
      0: rear = '0;
      1: rear = WIDTH_W'($urandom_range(8191));
      // Short rear readings hit the slow-down rule for most limit settings.
      default: rear = cm_to_width($urandom_range(30, 1));
    endcase
    if ($urandom_range(7) == 0)
      // Noise: four raw widths with no relation to each other.
      send_round(WIDTH_W'($urandom_range(8191)), WIDTH_W'($urandom_range(8191)),
                 WIDTH_W'($urandom_range(8191)), WIDTH_W'($urandom_range(8191)));
    else
      send_round(front_width(base, spread), front_width(base, spread),
                 front_width(base, spread), rear);
  endtask

  // Stop sending and wait until every predicted vote has come out. Then allow a few
  // more cycles, since a front beat still being converted gives no vote to wait for.
  // The wait is bounded so that a lost vote shows up as a leftover and not a hang.
  task automatic wait_idle();
    int unsigned waited;
    waited   = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (votes_owed != 0 && waited < 4000);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers on back-to-back cycles, only ever while idle.
  task automatic load_config(input logic [CM_W-1:0] tol, input logic [CM_W-1:0] near_lim,
                             input logic [CM_W-1:0] side_lim);
    cfg_write <= 1'b1;
    cfg_index <= REG_AGREE_TOL;
    cfg_data  <= tol;
    @(posedge clk);
    cfg_index <= REG_NEAR_LIMIT;
    cfg_data  <= near_lim;
    @(posedge clk);
    cfg_index <= REG_SIDE_LIMIT;
    cfg_data  <= side_lim;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rounds under the reset limits (tolerance 5, near 20, side 20 + 3).
    // All timeouts: no pair can agree and nothing is nonzero.
    send_round('0, '0, '0, '0);
    // Widths past the timeout read as zero, while the exact limit is 80 cm. So the
    // first nonzero front reading is the third one.
    send_round(WIDTH_W'(8191), TIMEOUT_US + WIDTH_W'(1), TIMEOUT_US, '0);
    // Close rear sensor with one short front reading: slow down wins over agreement.
    send_round(cm_to_width(10), cm_to_width(50), cm_to_width(50), cm_to_width(10));
    // All three pairs within tolerance: mean over the pair members.
    send_round(cm_to_width(50), cm_to_width(52), cm_to_width(54), '0);
    // One agreeing pair. The rear sensor sits right at the near limit, so no slow down.
    send_round(cm_to_width(50), cm_to_width(52), cm_to_width(70), cm_to_width(20));
    // A chain of two agreeing pairs gives no report.
    send_round(cm_to_width(50), cm_to_width(54), cm_to_width(58), '0);

    // A write to the spare index must leave every limit alone. The next round slows down
    // under the reset near and side limits, as it also would with either set to all ones.
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= '1;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    send_round(cm_to_width(22), cm_to_width(60), cm_to_width(61), cm_to_width(19));

    // Random phases. Each one settles, loads a register setting (the extremes first, the
    // reset values next, then random ones within the useful ranges) and picks one idling
    // pattern. Each wait for the block to drain is also a sender pause with every vote delivered.
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: load_config('0, '0, '0);
        1: load_config(7'd80, 7'd81, 7'd81);
        2: load_config('1, '1, '1);
        3: load_config(7'd5, 7'd20, 7'd23);
        default: load_config(CM_W'($urandom_range(80)), CM_W'($urandom_range(81)),
                             CM_W'($urandom_range(81)));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     <= 49;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct     <= 25;
        end
      endcase
      // In the phases without idling the receiver holds off for a long stretch while
      // beats keep coming. The vote queue fills up, and the rear beat then stalls.
      if (phase % 4 == 0) hold_ticket <= hold_ticket + 1;
      for (r = 0; r < 19; r++) send_random_round();
    end

    wait_idle();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
